// ===== sv/aia_pkg.sv =====
// shared types, codes and constants of the accumulating int64 alu
package aia_pkg;

	localparam int DW    = 64;
	localparam int OPW   = 5;
	localparam int ERRW  = 2;
	localparam int SHW   = 6;
	localparam int CNT_W = 6;

	localparam logic [DW-1:0]    SIGNED_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0]    ALL_ONES   = {DW{1'b1}};
	localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(DW - 1);

	typedef enum logic [OPW-1:0] {
		OP_LOAD = 5'd0,
		OP_ADD  = 5'd1,
		OP_SUB  = 5'd2,
		OP_MUL  = 5'd3,
		OP_DIV  = 5'd4,
		OP_MOD  = 5'd5,
		OP_AND  = 5'd6,
		OP_OR   = 5'd7,
		OP_XOR  = 5'd8,
		OP_SHL  = 5'd9,
		OP_SHR  = 5'd10,
		OP_LT   = 5'd11,
		OP_GT   = 5'd12,
		OP_LE   = 5'd13,
		OP_GE   = 5'd14,
		OP_EQ   = 5'd15,
		OP_NE   = 5'd16
	} opcode_t;

	typedef enum logic [ERRW-1:0] {
		ERR_NONE     = 2'd0,
		ERR_DIV_ZERO = 2'd1,
		ERR_MIN_NEG1 = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_AND,
		ALU_OR,
		ALU_XOR,
		ALU_SHL,
		ALU_SHR
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_NEGB,
		ST_DIV,
		ST_FIX
	} state_t;

	typedef struct packed {
		alu_op_t     op;
		logic        arith;
		logic [DW:0] x;
		logic [DW:0] y;
	} alu_req_t;

	typedef struct packed {
		logic [DW-1:0] res;
		logic          carry;
		logic          zero;
	} alu_rsp_t;

endpackage

// ===== sv/aia_if.sv =====
// item channels of the accumulating int64 alu
interface aia_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [aia_pkg::OPW-1:0]   opcode;
	logic                      is_signed;
	logic [aia_pkg::DW-1:0]    operand;

	modport source (output valid, output opcode, output is_signed, output operand,
		input ready);
	modport sink (input valid, input opcode, input is_signed, input operand,
		output ready);
endinterface

interface aia_result_if;
	logic                      valid;
	logic                      ready;
	logic [aia_pkg::DW-1:0]    value;
	logic                      compare_true;
	logic [aia_pkg::ERRW-1:0]  error_code;

	modport source (output valid, output value, output compare_true, output error_code,
		input ready);
	modport sink (input valid, input value, input compare_true, input error_code,
		output ready);
endinterface

// ===== sv/aia_alu.sv =====
// shared 65-bit add/subtract, logic and shift unit
module aia_alu (
	input  aia_pkg::alu_req_t req,
	output aia_pkg::alu_rsp_t rsp
);
	import aia_pkg::*;

	logic          sub;
	logic [DW:0]   y_eff;
	logic [DW+1:0] sum;
	logic [SHW-1:0] shamt;
	logic signed [DW-1:0] sx;

	always_comb begin
		sub   = (req.op == ALU_SUB);
		y_eff = sub ? ~req.y : req.y;
		sum   = {1'b0, req.x} + {1'b0, y_eff} + {{(DW+1){1'b0}}, sub};
		shamt = req.y[SHW-1:0];
		sx    = $signed(req.x[DW-1:0]);

		rsp.carry = sum[DW+1];
		rsp.zero  = (sum[DW-1:0] == '0);
		case (req.op)
			ALU_AND: rsp.res = req.x[DW-1:0] & req.y[DW-1:0];
			ALU_OR:  rsp.res = req.x[DW-1:0] | req.y[DW-1:0];
			ALU_XOR: rsp.res = req.x[DW-1:0] ^ req.y[DW-1:0];
			ALU_SHL: rsp.res = req.x[DW-1:0] << shamt;
			ALU_SHR: begin
				if (req.arith) begin
					rsp.res = DW'(sx >>> shamt);
				end else begin
					rsp.res = req.x[DW-1:0] >> shamt;
				end
			end
			default: rsp.res = sum[DW-1:0];
		endcase
	end
endmodule

// ===== sv/accumulating_int64_alu.sv =====
// accumulating int64 alu: top level with sequencer, accumulator and result register
// steps: load, add, sub, logic, shift and compare items finish in the execute step;
// mul runs 64 shift-add steps; div and mod take the magnitude of each operand, run 64
// restoring steps and fix the sign; a div or mod error finishes in the execute step
// one item at a time, all through the single shared unit; next item taken once idle
// with the result register free or being taken
// arst_n clears the sequencer, the result valid flag and the accumulator
module accumulating_int64_alu (
	input  logic          clk,
	input  logic          arst_n,
	aia_cmd_if.sink       cmd,
	aia_result_if.source  result
);
	import aia_pkg::*;

	state_t             state_q, state_d;
	logic [DW-1:0]      acc_q, acc_d;
	opcode_t            op_q;
	logic               sgn_q;
	logic [DW-1:0]      b_q, b_d;     // operand; multiplier, then divisor magnitude
	logic [DW-1:0]      x_q, x_d;     // multiplicand, or dividend shifting into quotient
	logic [DW-1:0]      r_q, r_d;     // product, or partial remainder
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               na_q, na_d;
	logic               nb_q, nb_d;

	logic               ov_q;
	logic [DW-1:0]      oval_q;
	logic               ocmp_q;
	err_t               oerr_q;

	logic               accept;
	logic               fin;
	logic [DW-1:0]      fin_val;
	logic               cmp_d;
	err_t               err_d;
	logic               lt;
	logic               eq;
	logic               neg;
	logic [DW-1:0]      fix_val;
	logic [DW-1:0]      smask;

	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;

	// negate through the shared adder, or pass the value unchanged
	function automatic alu_req_t neg_req(input logic n, input logic [DW-1:0] v);
		alu_req_t r;
		r.arith = 1'b0;
		if (n) begin
			r.op = ALU_SUB;
			r.x  = '0;
			r.y  = {1'b0, v};
		end else begin
			r.op = ALU_ADD;
			r.x  = {1'b0, v};
			r.y  = '0;
		end
		return r;
	endfunction

	aia_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// a new item may enter while the previous result is being taken
	assign cmd.ready = (state_q == ST_IDLE) && (!ov_q || result.ready);
	assign accept    = cmd.valid && cmd.ready;

	assign result.valid        = ov_q;
	assign result.value        = oval_q;
	assign result.compare_true = ocmp_q;
	assign result.error_code   = oerr_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, shared unit steering and datapath updates
	always_comb begin
		state_d = state_q;
		acc_d   = acc_q;
		b_d     = b_q;
		x_d     = x_q;
		r_d     = r_q;
		cnt_d   = cnt_q;
		na_d    = na_q;
		nb_d    = nb_q;
		fin     = 1'b0;
		fin_val = acc_q;
		cmp_d   = 1'b0;
		err_d   = ERR_NONE;
		neg     = 1'b0;
		fix_val = x_q;
		alu_req = '{op: ALU_ADD, arith: 1'b0, x: '0, y: '0};

		// signed compare by flipping the sign bits, then an unsigned subtract
		smask = {sgn_q, {(DW-1){1'b0}}};
		lt    = 1'b0;
		eq    = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					b_d     = cmd.operand;
					state_d = ST_EXEC;
				end
			end

			ST_EXEC: begin
				case (op_q)
					OP_LOAD: begin
						fin     = 1'b1;
						fin_val = b_q;
					end
					OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR, OP_SHL, OP_SHR: begin
						alu_req.x     = {1'b0, acc_q};
						alu_req.y     = {1'b0, b_q};
						alu_req.arith = sgn_q;
						case (op_q)
							OP_ADD:  alu_req.op = ALU_ADD;
							OP_SUB:  alu_req.op = ALU_SUB;
							OP_AND:  alu_req.op = ALU_AND;
							OP_OR:   alu_req.op = ALU_OR;
							OP_XOR:  alu_req.op = ALU_XOR;
							OP_SHL:  alu_req.op = ALU_SHL;
							default: alu_req.op = ALU_SHR;
						endcase
						fin     = 1'b1;
						fin_val = alu_rsp.res;
					end
					OP_MUL: begin
						r_d     = '0;
						x_d     = acc_q;
						cnt_d   = '0;
						state_d = ST_MUL;
					end
					OP_DIV, OP_MOD: begin
						if (b_q == '0) begin
							fin   = 1'b1;
							err_d = ERR_DIV_ZERO;
						end else if (sgn_q && (b_q == ALL_ONES) && (acc_q == SIGNED_MIN)) begin
							fin   = 1'b1;
							err_d = ERR_MIN_NEG1;
						end else begin
							// dividend magnitude now, divisor magnitude next cycle
							neg     = sgn_q & acc_q[DW-1];
							alu_req = neg_req(neg, acc_q);
							x_d     = alu_rsp.res;
							na_d    = neg;
							nb_d    = sgn_q & b_q[DW-1];
							r_d     = '0;
							cnt_d   = '0;
							state_d = ST_NEGB;
						end
					end
					OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE: begin
						alu_req.op = ALU_SUB;
						alu_req.x  = {1'b0, acc_q ^ smask};
						alu_req.y  = {1'b0, b_q ^ smask};
						lt         = !alu_rsp.carry;
						eq         = alu_rsp.zero;
						case (op_q)
							OP_LT:   cmp_d = lt;
							OP_GT:   cmp_d = !lt && !eq;
							OP_LE:   cmp_d = lt || eq;
							OP_GE:   cmp_d = !lt;
							OP_EQ:   cmp_d = eq;
							default: cmp_d = !eq;
						endcase
						fin = 1'b1;
					end
					default: begin
						// unused opcodes leave the accumulator alone
						fin = 1'b1;
					end
				endcase
			end

			ST_MUL: begin
				// add the shifted multiplicand where the multiplier bit is set
				alu_req.op = ALU_ADD;
				alu_req.x  = {1'b0, r_q};
				alu_req.y  = b_q[0] ? {1'b0, x_q} : '0;
				r_d        = alu_rsp.res;
				x_d        = {x_q[DW-2:0], 1'b0};
				b_d        = {1'b0, b_q[DW-1:1]};
				cnt_d      = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					fin     = 1'b1;
					fin_val = alu_rsp.res;
				end
			end

			ST_NEGB: begin
				alu_req = neg_req(nb_q, b_q);
				b_d     = alu_rsp.res;
				state_d = ST_DIV;
			end

			ST_DIV: begin
				// restoring step: trial subtract of the divisor from the shifted remainder
				alu_req.op = ALU_SUB;
				alu_req.x  = {r_q, x_q[DW-1]};
				alu_req.y  = {1'b0, b_q};
				if (alu_rsp.carry) begin
					r_d = alu_rsp.res;
					x_d = {x_q[DW-2:0], 1'b1};
				end else begin
					r_d = {r_q[DW-2:0], x_q[DW-1]};
					x_d = {x_q[DW-2:0], 1'b0};
				end
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_FIX;
				end
			end

			ST_FIX: begin
				// quotient sign from both operands, remainder sign from the dividend
				if (op_q == OP_DIV) begin
					fix_val = x_q;
					neg     = na_q ^ nb_q;
				end else begin
					fix_val = r_q;
					neg     = na_q;
				end
				alu_req = neg_req(neg, fix_val);
				fin     = 1'b1;
				fin_val = alu_rsp.res;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (fin) begin
			acc_d   = fin_val;
			state_d = ST_IDLE;
		end
	end

	// accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			acc_q <= acc_d;
		end
	end

	// working registers of the shared unit
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= opcode_t'(cmd.opcode);
			sgn_q <= cmd.is_signed;
		end
		b_q   <= b_d;
		x_q   <= x_d;
		r_q   <= r_d;
		cnt_q <= cnt_d;
		na_q  <= na_d;
		nb_q  <= nb_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (fin) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			oval_q <= fin_val;
			ocmp_q <= cmp_d;
			oerr_q <= err_d;
		end
	end

	// the block only takes an item while its sequencer is idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> (state_q == ST_IDLE))
		else $error("item taken while the sequencer is busy");

	// a waiting result always shows the accumulator it left behind
	a_result_acc: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (oval_q == acc_q))
		else $error("result value differs from the accumulator");

	// a compare flag and an error never come together
	a_cmp_err: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> !(ocmp_q && (oerr_q != ERR_NONE)))
		else $error("compare flag raised with an error code");

	// the divide loop runs all its steps
	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DIV) && (cnt_q != CNT_LAST)) |=> (state_q == ST_DIV))
		else $error("divide loop left early");

	// a fresh accepted item always starts in the execute step
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted item did not start");

endmodule
